// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the share inner product block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rsip_pkg.sv -----
// ----------------------------------------------------------------------------
// rsip_pkg
// Types and constants shared by the share inner product block.
// ----------------------------------------------------------------------------
package rsip_pkg;

	// Width of one share and of the ring modulus.
	localparam int SHARE_W = 31;
	// Full product of two shares.
	localparam int PROD_W  = 2 * SHARE_W;
	// Product plus a running sum: one bit of headroom.
	localparam int RED_W   = PROD_W + 1;
	// Bit counter for the serial reduction.
	localparam int CNT_W   = $clog2(RED_W);

	// Smallest modulus that is ever used.
	localparam logic [SHARE_W-1:0] MOD_MIN   = SHARE_W'(2);
	localparam logic [SHARE_W-1:0] MOD_RESET = {SHARE_W{1'b1}};

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_QUERY    = 2'd1,
		OP_TRUNCATE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INSERT_DONE = 2'd0,
		ST_SUM_READY   = 2'd1,
		ST_TABLE_FULL  = 2'd2,
		ST_MISMATCH    = 2'd3
	} status_t;

endpackage

// ----- rtl/rsip_ram.sv -----
// ----------------------------------------------------------------------------
// rsip_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsip_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/rsip_mac_unit.sv -----
// ----------------------------------------------------------------------------
// rsip_mac_unit
// Shared modular multiply-accumulate: result = (x * y + acc) mod m.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsip_mac_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rsip_pkg::SHARE_W-1:0] op_x,
	input  logic [rsip_pkg::SHARE_W-1:0] op_y,
	input  logic [rsip_pkg::SHARE_W-1:0] acc,
	input  logic [rsip_pkg::SHARE_W-1:0] modulus,
	output logic                         done,
	output logic [rsip_pkg::SHARE_W-1:0] result
);

	import rsip_pkg::*;

	typedef enum logic [4:0] {
		M_IDLE = 5'b00001,
		M_MUL  = 5'b00010,
		M_ADD  = 5'b00100,
		M_RED  = 5'b01000,
		M_DONE = 5'b10000
	} mac_state_t;

	localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(RED_W - 1);

	mac_state_t         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SHARE_W-1:0] x_q, y_q, acc_q, m_q, r_q;
	logic [PROD_W-1:0]  prod_q;
	logic [RED_W-1:0]   shift_q;
	logic [SHARE_W:0]   cand;
	logic [SHARE_W:0]   diff;
	logic [SHARE_W-1:0] r_next;

	// One restoring step: bring in the next bit and subtract the modulus once.
	always_comb begin
		cand   = {r_q, shift_q[RED_W-1]};
		diff   = cand - {1'b0, m_q};
		r_next = (cand >= {1'b0, m_q}) ? diff[SHARE_W-1:0] : cand[SHARE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					state_q <= M_ADD;
				end
				M_ADD: begin
					cnt_q   <= '0;
					state_q <= M_RED;
				end
				M_RED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RED_LAST) begin
						state_q <= M_DONE;
					end
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			x_q   <= op_x;
			y_q   <= op_y;
			acc_q <= acc;
			m_q   <= modulus;
		end
		if (state_q == M_MUL) begin
			prod_q <= x_q * y_q;
		end
		if (state_q == M_ADD) begin
			shift_q <= {1'b0, prod_q} + RED_W'(acc_q);
			r_q     <= '0;
		end
		if (state_q == M_RED) begin
			shift_q <= {shift_q[RED_W-2:0], 1'b0};
			r_q     <= r_next;
		end
	end

	assign done   = (state_q == M_DONE);
	assign result = r_q;

	`ASSERT_IMP(a_result_reduced, clk, arst_n, done, r_q < m_q, "result not below modulus")

endmodule

// ----- rtl/replicated_share_inner_product.sv -----
// ----------------------------------------------------------------------------
// replicated_share_inner_product
// Table of replicated share pairs with a streamed, modular inner product.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                Payload
//  -------   ----------------------   --------------------------------------
//  command   cmd_valid / cmd_stall    opcode, share_first, share_second, last
//  result    res_valid / res_stall    status, sum_value
//  config    cfg_we (no wait)         cfg_wdata (modulus)
//
//  A query element that hits a stored entry stalls commands for one table read
//  and then three passes of the shared multiply-accumulate unit, each set by its
//  63-step bit-serial reduction. A transaction with a result also stalls while
//  it posts the result, and longer while the previous result is held off;
//  truncate, an ignored opcode and a non-final surplus element add no stall.
//  Reset clears the entry count and query state, modulus to maximum.
//
`include "assert_macros.svh"

module replicated_share_inner_product #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Command channel
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [1:0]                   opcode,
	input  logic [rsip_pkg::SHARE_W-1:0] share_first,
	input  logic [rsip_pkg::SHARE_W-1:0] share_second,
	input  logic                         last,
	// Result channel
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   status,
	output logic [rsip_pkg::SHARE_W-1:0] sum_value,
	// Modulus register
	input  logic                         cfg_we,
	input  logic [rsip_pkg::SHARE_W-1:0] cfg_wdata
);

	import rsip_pkg::*;

	// Query position may sit one beyond the entry count to mark a mismatch.
	localparam int QW = $clog2(TABLE_DEPTH + 2);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [QW-1:0] DEPTH_Q = QW'(TABLE_DEPTH);

	// Which of the three cross products is being accumulated.
	localparam logic [1:0] TERM_AC = 2'd0;
	localparam logic [1:0] TERM_AD = 2'd1;
	localparam logic [1:0] TERM_BC = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_READ     = 5'b00010,
		S_MAC_GO   = 5'b00100,
		S_MAC_WAIT = 5'b01000,
		S_EMIT     = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [QW-1:0]      entry_count_q, entry_count_d;
	logic [QW-1:0]      query_pos_q, query_pos_d;
	logic [SHARE_W-1:0] run_sum_q, run_sum_d;
	logic [1:0]         term_q, term_d;
	logic [SHARE_W-1:0] modulus_q;
	logic               res_valid_q, res_valid_d;

	// Payload registers.
	logic [SHARE_W-1:0] a_q, b_q, c_q, d_q;
	logic               last_q;
	status_t            pend_status_q, res_status_q;
	logic [SHARE_W-1:0] pend_sum_q, res_sum_q;

	logic               accept;
	logic               go_emit;
	status_t            emit_status;
	logic [SHARE_W-1:0] emit_sum;
	logic               ld_query;
	logic               res_load;
	logic [QW-1:0]      query_pos_inc;

	logic                      ram_wr_en;
	logic [2*SHARE_W-1:0]      ram_rd_data;
	logic [SHARE_W-1:0]        mod_eff;
	logic                      mac_start;
	logic                      mac_done;
	logic [SHARE_W-1:0]        mac_x, mac_y, mac_result;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);

	// A modulus of zero or one behaves as two.
	assign mod_eff = (modulus_q < MOD_MIN) ? MOD_MIN : modulus_q;

	assign query_pos_inc = query_pos_q + 1'b1;

	// Inserts write straight into the table when there is room.
	assign ram_wr_en = accept && (opcode == OP_INSERT) && (entry_count_q < DEPTH_Q);

	rsip_ram #(
		.WIDTH (2 * SHARE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (entry_count_q[AW-1:0]),
		.wr_data ({share_first, share_second}),
		.rd_addr (query_pos_q[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// The stored pair (a, b) meets the query pair (c, d) as a*c, a*d and b*c.
	assign mac_x     = (term_q == TERM_BC) ? b_q : a_q;
	assign mac_y     = (term_q == TERM_AD) ? d_q : c_q;
	assign mac_start = (state_q == S_MAC_GO);

	rsip_mac_unit u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.op_x    (mac_x),
		.op_y    (mac_y),
		.acc     (run_sum_q),
		.modulus (mod_eff),
		.done    (mac_done),
		.result  (mac_result)
	);

	// Sequencer: decides the next table and query state and any result.
	always_comb begin
		state_d       = state_q;
		entry_count_d = entry_count_q;
		query_pos_d   = query_pos_q;
		run_sum_d     = run_sum_q;
		term_d        = term_q;
		go_emit       = 1'b0;
		emit_status   = ST_INSERT_DONE;
		emit_sum      = '0;
		ld_query      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_INSERT: begin
							// An insert abandons any query in progress.
							query_pos_d = '0;
							run_sum_d   = '0;
							go_emit     = 1'b1;
							if (entry_count_q >= DEPTH_Q) begin
								emit_status = ST_TABLE_FULL;
							end else begin
								entry_count_d = entry_count_q + 1'b1;
								emit_status   = ST_INSERT_DONE;
							end
						end
						OP_QUERY: begin
							ld_query = 1'b1;
							if (query_pos_q < entry_count_q) begin
								state_d = S_READ;
							end else begin
								// Surplus element: park the position past the count.
								query_pos_d = entry_count_q + 1'b1;
								if (last) begin
									go_emit     = 1'b1;
									emit_status = ST_MISMATCH;
									query_pos_d = '0;
									run_sum_d   = '0;
								end
							end
						end
						OP_TRUNCATE: begin
							entry_count_d = '0;
							query_pos_d   = '0;
							run_sum_d     = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				term_d  = TERM_AC;
				state_d = S_MAC_GO;
			end
			S_MAC_GO: begin
				state_d = S_MAC_WAIT;
			end
			S_MAC_WAIT: begin
				if (mac_done) begin
					run_sum_d = mac_result;
					if (term_q == TERM_BC) begin
						query_pos_d = query_pos_inc;
						state_d     = S_IDLE;
						if (last_q) begin
							go_emit     = 1'b1;
							query_pos_d = '0;
							run_sum_d   = '0;
							if (query_pos_inc == entry_count_q) begin
								emit_status = ST_SUM_READY;
								emit_sum    = mac_result;
							end else begin
								emit_status = ST_MISMATCH;
							end
						end
					end else begin
						term_d  = term_q + 1'b1;
						state_d = S_MAC_GO;
					end
				end
			end
			S_EMIT: begin
				if (!res_valid_q || !res_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (go_emit) begin
			state_d = S_EMIT;
		end
	end

	// The output register takes the pending result once it is free.
	assign res_load = (state_q == S_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		res_valid_d = res_valid_q;
		if (res_valid_q && !res_stall) begin
			res_valid_d = 1'b0;
		end
		if (res_load) begin
			res_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_count_q <= '0;
			query_pos_q   <= '0;
			run_sum_q     <= '0;
			term_q        <= TERM_AC;
			modulus_q     <= MOD_RESET;
			res_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			entry_count_q <= entry_count_d;
			query_pos_q   <= query_pos_d;
			run_sum_q     <= run_sum_d;
			term_q        <= term_d;
			res_valid_q   <= res_valid_d;
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_query) begin
			c_q    <= share_first;
			d_q    <= share_second;
			last_q <= last;
		end
		if (state_q == S_READ) begin
			a_q <= ram_rd_data[2*SHARE_W-1:SHARE_W];
			b_q <= ram_rd_data[SHARE_W-1:0];
		end
		if (go_emit) begin
			pend_status_q <= emit_status;
			pend_sum_q    <= emit_sum;
		end
		if (res_load) begin
			res_status_q <= pend_status_q;
			res_sum_q    <= pend_sum_q;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = res_status_q;
	assign sum_value = res_sum_q;

	`ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, entry_count_q <= DEPTH_Q, "entry count beyond table depth")
	`ASSERT_IMP(a_qpos_bound, clk, arst_n, 1'b1, query_pos_q <= entry_count_q + 1'b1, "query position out of range")
	`ASSERT_IMP(a_mac_done_waiting, clk, arst_n, mac_done, state_q == S_MAC_WAIT, "accumulate finished while not awaited")
	`ASSERT_NEXT(a_emit_loads, clk, arst_n, res_load, res_valid_q && state_q == S_IDLE, "pending result not posted")

endmodule
